>>> hdl/svag_pkg.sv
// Shared constants for the strided view address generator.
// No dependencies; used by strided_view_address_gen_core.
package svag_pkg;

  localparam int unsigned MAX_RANK_DEF    = 3;
  localparam int unsigned INDEX_WIDTH_DEF = 24;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned SIZE_W          = 16;
  localparam int unsigned STRIDE_W        = 24;
  localparam int unsigned PROD_W          = SIZE_W + STRIDE_W;
  localparam int unsigned AXES            = 3;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_MODE       = 3'd0,
    REG_BASE_OFFSET     = 3'd1,
    REG_DIM_SIZE_OUTER  = 3'd2,
    REG_DIM_SIZE_MIDDLE = 3'd3,
    REG_DIM_SIZE_INNER  = 3'd4,
    REG_STRIDE_OUTER    = 3'd5,
    REG_STRIDE_MIDDLE   = 3'd6,
    REG_STRIDE_INNER    = 3'd7
  } cfg_reg_t;

endpackage

>>> hdl/strided_view_address_gen_core.sv
// Strided view address generator: flat index to source element address.
// Depends on svag_pkg.
//
//   channel | ports                                   | direction
//   input   | start, busy, in_element_index           | in (busy out)
//   result  | out_valid, out_dest_index, out_source_address | out
//   config  | cfg_we, cfg_index, cfg_data             | in
//
// One beat enters every cycle while busy is low. Its result passes the entry
// register and then the restoring divider: one quotient bit per stage for
// each axis, then a multiply stage and an accumulate stage.
// busy is high during reset and in the first cycle after it. Results cannot be stalled.
// Synchronous active-low reset clears the valid bits and sets the config registers to their defaults.
module strided_view_address_gen_core #(
  parameter int unsigned MAX_RANK    = svag_pkg::MAX_RANK_DEF,
  parameter int unsigned INDEX_WIDTH = svag_pkg::INDEX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [INDEX_WIDTH-1:0]          in_element_index,
  output logic                            out_valid,
  output logic [INDEX_WIDTH-1:0]          out_dest_index,
  output logic [svag_pkg::ADDR_W-1:0]     out_source_address,
  input  logic                            cfg_we,
  input  logic [svag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svag_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned W   = INDEX_WIDTH;
  localparam int unsigned AXW = W + 2;
  localparam int unsigned NS  = MAX_RANK * AXW + 1;

  typedef struct packed {
    logic                          v;
    logic [W-1:0]                  idx;
    logic [W-1:0]                  num;
    logic [svag_pkg::SIZE_W-1:0]   rem;
    logic [svag_pkg::PROD_W-1:0]   prod;
    logic [svag_pkg::ADDR_W-1:0]   addr;
  } stage_t;

  logic                          view_mode_r;
  logic [svag_pkg::ADDR_W-1:0]   base_offset_r;
  logic [svag_pkg::SIZE_W-1:0]   size_r   [svag_pkg::AXES];
  logic [svag_pkg::STRIDE_W-1:0] stride_r [svag_pkg::AXES];
  logic                          busy_r;
  stage_t                        pipe_r   [NS];

  // Registers are kept innermost axis first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_mode_r   <= 1'b0;
      base_offset_r <= '0;
      size_r[0]     <= svag_pkg::SIZE_W'(1);
      size_r[1]     <= svag_pkg::SIZE_W'(1);
      size_r[2]     <= svag_pkg::SIZE_W'(1);
      stride_r[0]   <= svag_pkg::STRIDE_W'(1);
      stride_r[1]   <= '0;
      stride_r[2]   <= '0;
    end else if (cfg_we) begin
      unique case (svag_pkg::cfg_reg_t'(cfg_index))
        svag_pkg::REG_VIEW_MODE:       view_mode_r   <= cfg_data[0];
        svag_pkg::REG_BASE_OFFSET:     base_offset_r <= cfg_data;
        svag_pkg::REG_DIM_SIZE_OUTER:  size_r[2]     <= cfg_data[svag_pkg::SIZE_W-1:0];
        svag_pkg::REG_DIM_SIZE_MIDDLE: size_r[1]     <= cfg_data[svag_pkg::SIZE_W-1:0];
        svag_pkg::REG_DIM_SIZE_INNER:  size_r[0]     <= cfg_data[svag_pkg::SIZE_W-1:0];
        svag_pkg::REG_STRIDE_OUTER:    stride_r[2]   <= cfg_data[svag_pkg::STRIDE_W-1:0];
        svag_pkg::REG_STRIDE_MIDDLE:   stride_r[1]   <= cfg_data[svag_pkg::STRIDE_W-1:0];
        svag_pkg::REG_STRIDE_INNER:    stride_r[0]   <= cfg_data[svag_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end
  assign busy = busy_r;

  // Entry stage: the remainder starts at zero and the sum at the base offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r[0].v <= 1'b0;
    end else begin
      pipe_r[0].v <= start && !busy_r;
    end
    pipe_r[0].idx  <= in_element_index;
    pipe_r[0].num  <= in_element_index;
    pipe_r[0].rem  <= '0;
    pipe_r[0].prod <= '0;
    pipe_r[0].addr <= base_offset_r;
  end

  genvar a, b;
  generate
    for (a = 0; a < MAX_RANK; a++) begin : g_axis
      // A zero size behaves as size one.
      logic [svag_pkg::SIZE_W-1:0] div;
      assign div = (size_r[a] == '0) ? svag_pkg::SIZE_W'(1) : size_r[a];

      for (b = 0; b < W; b++) begin : g_div
        localparam int unsigned J = a * AXW + 1 + b;
        logic [svag_pkg::SIZE_W:0] trial;
        logic                      ge;
        logic [svag_pkg::SIZE_W:0] diff;
        assign trial = {pipe_r[J-1].rem, pipe_r[J-1].num[W-1]};
        assign ge    = trial >= {1'b0, div};
        assign diff  = trial - {1'b0, div};
        always_ff @(posedge clk) begin
          if (!rst_n) pipe_r[J].v <= 1'b0;
          else        pipe_r[J].v <= pipe_r[J-1].v;
          pipe_r[J].idx  <= pipe_r[J-1].idx;
          pipe_r[J].num  <= {pipe_r[J-1].num[W-2:0], ge};
          pipe_r[J].rem  <= ge ? diff[svag_pkg::SIZE_W-1:0] : trial[svag_pkg::SIZE_W-1:0];
          pipe_r[J].prod <= '0;
          pipe_r[J].addr <= pipe_r[J-1].addr;
        end
      end

      localparam int unsigned JM = a * AXW + 1 + W;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pipe_r[JM].v   <= 1'b0;
          pipe_r[JM+1].v <= 1'b0;
        end else begin
          pipe_r[JM].v   <= pipe_r[JM-1].v;
          pipe_r[JM+1].v <= pipe_r[JM].v;
        end
        pipe_r[JM].idx  <= pipe_r[JM-1].idx;
        pipe_r[JM].num  <= pipe_r[JM-1].num;
        pipe_r[JM].rem  <= '0;
        pipe_r[JM].prod <= pipe_r[JM-1].rem * stride_r[a];
        pipe_r[JM].addr <= pipe_r[JM-1].addr;
        // The quotient goes on as the index of the next axis out.
        pipe_r[JM+1].idx  <= pipe_r[JM].idx;
        pipe_r[JM+1].num  <= pipe_r[JM].num;
        pipe_r[JM+1].rem  <= '0;
        pipe_r[JM+1].prod <= '0;
        pipe_r[JM+1].addr <= pipe_r[JM].addr + pipe_r[JM].prod[svag_pkg::ADDR_W-1:0];
      end
    end
  endgenerate

  assign out_valid          = pipe_r[NS-1].v;
  assign out_dest_index     = pipe_r[NS-1].idx;
  assign out_source_address = view_mode_r ? pipe_r[NS-1].addr
                                          : svag_pkg::ADDR_W'(pipe_r[NS-1].idx);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, NS) |-> (out_valid == $past(start && !busy_r, NS)))
    else $error("result beat does not match accepted beat");

  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !view_mode_r) |->
      (out_source_address == svag_pkg::ADDR_W'(out_dest_index)))
    else $error("contiguous address differs from index");

  a_zero_stride: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && view_mode_r && stride_r[0] == '0 && stride_r[1] == '0
     && stride_r[2] == '0) |-> (out_source_address == base_offset_r))
    else $error("zero strides must give the base offset");

  a_busy: assert property (@(posedge clk) $past(rst_n) |-> !busy)
    else $error("busy after reset release");

endmodule
